// ===== design/hpwf_pkg.sv =====
// Package with the shared types, constants and the arctangent table of the waypoint follower.
`default_nettype none
package hpwf_pkg;
   localparam int CORDIC_STEPS = 14;
   localparam int STEP_WIDTH = 4;
   localparam logic signed [17:0] ANG_PI = 18'sd25736;
   localparam logic signed [17:0] ANG_TWO_PI = 18'sd51472;

   localparam logic [2:0] REG_TURN_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_MAX_SPEED = 3'd1;
   localparam logic [2:0] REG_GAIN_P = 3'd2;
   localparam logic [2:0] REG_GAIN_I = 3'd3;
   localparam logic [2:0] REG_GAIN_D = 3'd4;
   localparam logic [2:0] REG_ARRIVE_RADIUS = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIFF, ST_DIST, ST_DIST_SUM, ST_ARRIVE, ST_CORDIC, ST_WRAP,
      ST_DECIDE, ST_MUL_P, ST_MUL_I, ST_MUL_D, ST_ROUND, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic diff;
      logic square;
      logic dist_sum;
      logic cordic_init;
      logic cordic_step;
      logic wrap;
      logic decide;
      logic mul_p;
      logic mul_i;
      logic mul_d;
      logic round;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic arrived;
      logic turn;
      logic cordic_done;
   } status_type;

   function automatic logic [12:0] atan_entry(input logic [STEP_WIDTH-1:0] idx);
      logic [12:0] v;
      unique case (idx)
         4'd0: v = 13'd6434;
         4'd1: v = 13'd3798;
         4'd2: v = 13'd2007;
         4'd3: v = 13'd1019;
         4'd4: v = 13'd511;
         4'd5: v = 13'd256;
         4'd6: v = 13'd128;
         4'd7: v = 13'd64;
         4'd8: v = 13'd32;
         4'd9: v = 13'd16;
         4'd10: v = 13'd8;
         4'd11: v = 13'd4;
         4'd12: v = 13'd2;
         4'd13: v = 13'd1;
         default: v = 13'd0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

// ===== design/hpwf_ctrl.sv =====
// Controller state machine that sequences one word through the datapath.
`default_nettype none
module hpwf_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic out_busy,
   input  wire hpwf_pkg::status_type status,
   output hpwf_pkg::cmd_type cmd
);
   hpwf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hpwf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hpwf_pkg::ST_IDLE: if (req_valid) state_in = hpwf_pkg::ST_DIFF;
         hpwf_pkg::ST_DIFF: state_in = hpwf_pkg::ST_DIST;
         hpwf_pkg::ST_DIST: state_in = hpwf_pkg::ST_DIST_SUM;
         hpwf_pkg::ST_DIST_SUM: state_in = hpwf_pkg::ST_ARRIVE;
         hpwf_pkg::ST_ARRIVE: begin
            if (status.arrived) state_in = hpwf_pkg::ST_OUT;
            else state_in = hpwf_pkg::ST_CORDIC;
         end
         hpwf_pkg::ST_CORDIC: if (status.cordic_done) state_in = hpwf_pkg::ST_WRAP;
         hpwf_pkg::ST_WRAP: state_in = hpwf_pkg::ST_DECIDE;
         hpwf_pkg::ST_DECIDE: begin
            if (status.turn) state_in = hpwf_pkg::ST_OUT;
            else state_in = hpwf_pkg::ST_MUL_P;
         end
         hpwf_pkg::ST_MUL_P: state_in = hpwf_pkg::ST_MUL_I;
         hpwf_pkg::ST_MUL_I: state_in = hpwf_pkg::ST_MUL_D;
         hpwf_pkg::ST_MUL_D: state_in = hpwf_pkg::ST_ROUND;
         hpwf_pkg::ST_ROUND: state_in = hpwf_pkg::ST_OUT;
         hpwf_pkg::ST_OUT: if (!out_busy) state_in = hpwf_pkg::ST_IDLE;
         default: state_in = hpwf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         hpwf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
         end
         hpwf_pkg::ST_DIFF: cmd.diff = 1'b1;
         hpwf_pkg::ST_DIST: cmd.square = 1'b1;
         hpwf_pkg::ST_DIST_SUM: cmd.dist_sum = 1'b1;
         hpwf_pkg::ST_ARRIVE: cmd.cordic_init = 1'b1;
         hpwf_pkg::ST_CORDIC: cmd.cordic_step = 1'b1;
         hpwf_pkg::ST_WRAP: cmd.wrap = 1'b1;
         hpwf_pkg::ST_DECIDE: cmd.decide = 1'b1;
         hpwf_pkg::ST_MUL_P: cmd.mul_p = 1'b1;
         hpwf_pkg::ST_MUL_I: cmd.mul_i = 1'b1;
         hpwf_pkg::ST_MUL_D: cmd.mul_d = 1'b1;
         hpwf_pkg::ST_ROUND: cmd.round = 1'b1;
         hpwf_pkg::ST_OUT: cmd.finish = !out_busy;
         default: cmd = '0;
      endcase
   end
endmodule
`default_nettype wire

// ===== design/hpwf_datapath.sv =====
// Datapath with the distance check, CORDIC unit, PID arithmetic and output register.
`default_nettype none
module hpwf_datapath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire hpwf_pkg::cmd_type cmd,
   output hpwf_pkg::status_type status,
   output logic out_busy,
   input  wire logic signed [31:0] req_pose_x,
   input  wire logic signed [31:0] req_pose_y,
   input  wire logic signed [15:0] req_pose_yaw,
   input  wire logic signed [31:0] req_goal_x,
   input  wire logic signed [31:0] req_goal_y,
   input  wire logic csr_write,
   input  wire logic [2:0] csr_index,
   input  wire logic [15:0] csr_data,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic signed [15:0] rsp_left_speed,
   output logic signed [15:0] rsp_right_speed,
   output logic rsp_waypoint_reached
);
   logic [14:0] turn_threshold_ff;
   logic [14:0] max_speed_ff;
   logic signed [15:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [15:0] arrive_radius_ff;

   logic signed [31:0] px_ff, py_ff, gx_ff, gy_ff;
   logic signed [15:0] yaw_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic [31:0] dx2_ff, dy2_ff;
   logic [32:0] d2_ff;
   logic [31:0] r2_ff;
   logic near_ff;
   logic signed [35:0] cx_ff, cy_ff;
   logic signed [17:0] cz_ff;
   logic [hpwf_pkg::STEP_WIDTH-1:0] step_ff;
   logic signed [17:0] err_ff;
   logic signed [15:0] e16_ff;
   logic signed [31:0] error_sum_ff, sum_new_ff;
   logic signed [15:0] last_error_ff;
   logic signed [49:0] acc_ff;
   logic signed [15:0] left_ff, right_ff;
   logic reached_ff, valid_ff;
   logic signed [15:0] rsp_left_ff, rsp_right_ff;
   logic rsp_reached_ff;

   logic [32:0] adx, ady;
   logic signed [35:0] xs, ys;
   logic signed [17:0] werr;
   logic [17:0] abs_err;
   logic signed [32:0] sum_wide;
   logic signed [16:0] deriv;
   logic signed [28:0] corr;
   logic signed [16:0] half, maxs;
   logic signed [29:0] left_raw, right_raw;

   assign adx = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign ady = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
   assign xs = cx_ff >>> step_ff;
   assign ys = cy_ff >>> step_ff;
   assign status.cordic_done = (step_ff == 4'(hpwf_pkg::CORDIC_STEPS - 1));
   assign status.arrived = near_ff && (d2_ff < {1'b0, r2_ff});
   assign abs_err = err_ff[17] ? 18'(-err_ff) : err_ff;
   assign status.turn = abs_err > {3'd0, turn_threshold_ff};
   assign sum_wide = 33'(error_sum_ff) + 33'(e16_ff);
   assign deriv = 17'(e16_ff) - 17'(last_error_ff);
   assign half = {3'b000, max_speed_ff[14:1]};
   assign maxs = {2'b00, max_speed_ff};
   assign corr = 29'((acc_ff + 50'sd1048576) >>> 21);
   assign left_raw = 30'(half) - 30'(corr);
   assign right_raw = 30'(half) + 30'(corr);

   always_comb begin
      werr = err_ff;
      if (err_ff > hpwf_pkg::ANG_PI) werr = err_ff - hpwf_pkg::ANG_TWO_PI;
      else if (err_ff < -hpwf_pkg::ANG_PI) werr = err_ff + hpwf_pkg::ANG_TWO_PI;
   end

   function automatic logic signed [15:0] clampv(input logic signed [29:0] v,
                                                 input logic signed [16:0] m);
      logic signed [15:0] r;
      if (v > 30'(m)) r = 16'(m);
      else if (v < -30'(m)) r = 16'(-m);
      else r = 16'(v);
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_threshold_ff <= 15'd8192;
         max_speed_ff <= 15'd16384;
         gain_p_ff <= 16'sd256;
         gain_i_ff <= 16'sd0;
         gain_d_ff <= 16'sd0;
         arrive_radius_ff <= 16'd655;
         error_sum_ff <= '0;
         last_error_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               hpwf_pkg::REG_TURN_THRESHOLD: turn_threshold_ff <= csr_data[14:0];
               hpwf_pkg::REG_MAX_SPEED: max_speed_ff <= csr_data[14:0];
               hpwf_pkg::REG_GAIN_P: gain_p_ff <= csr_data;
               hpwf_pkg::REG_GAIN_I: gain_i_ff <= csr_data;
               hpwf_pkg::REG_GAIN_D: gain_d_ff <= csr_data;
               hpwf_pkg::REG_ARRIVE_RADIUS: arrive_radius_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.decide && !status.turn) begin
            sum_new_ff <= sum_wide > 33'sh0_7FFF_FFFF ? 32'sh7FFF_FFFF :
                          sum_wide < -33'sh0_8000_0000 ? 32'sh8000_0000 : 32'(sum_wide);
         end
         if (cmd.mul_i) begin
            error_sum_ff <= sum_new_ff;
         end
         if (cmd.mul_d) last_error_ff <= e16_ff;
         if (cmd.finish) valid_ff <= 1'b1;
         else if (valid_ff && !rsp_stall) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff <= req_pose_x;
         py_ff <= req_pose_y;
         gx_ff <= req_goal_x;
         gy_ff <= req_goal_y;
         yaw_ff <= req_pose_yaw;
         reached_ff <= 1'b0;
      end
      if (cmd.diff) begin
         dx_ff <= 33'(gx_ff) - 33'(px_ff);
         dy_ff <= 33'(gy_ff) - 33'(py_ff);
      end
      if (cmd.square) begin
         dx2_ff <= adx[15:0] * adx[15:0];
         dy2_ff <= ady[15:0] * ady[15:0];
         r2_ff <= arrive_radius_ff * arrive_radius_ff;
         near_ff <= (adx < {17'd0, arrive_radius_ff}) && (ady < {17'd0, arrive_radius_ff});
      end
      if (cmd.dist_sum) begin
         d2_ff <= 33'(dx2_ff) + 33'(dy2_ff);
      end
      if (cmd.cordic_init) begin
         step_ff <= '0;
         if (dx_ff < 0) begin
            cx_ff <= -36'(dx_ff);
            cy_ff <= -36'(dy_ff);
            cz_ff <= dy_ff >= 0 ? hpwf_pkg::ANG_PI : -hpwf_pkg::ANG_PI;
         end else begin
            cx_ff <= 36'(dx_ff);
            cy_ff <= 36'(dy_ff);
            cz_ff <= '0;
         end
         if (status.arrived) begin
            reached_ff <= 1'b1;
            left_ff <= '0;
            right_ff <= '0;
         end
      end
      if (cmd.cordic_step) begin
         step_ff <= step_ff + 1'b1;
         if (cy_ff >= 0) begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + 18'(hpwf_pkg::atan_entry(step_ff));
         end else begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - 18'(hpwf_pkg::atan_entry(step_ff));
         end
         if (status.cordic_done) begin
            if (dx_ff == 0 && dy_ff == 0) err_ff <= -18'(yaw_ff);
            else err_ff <= cz_ff + (cy_ff >= 0 ? 18'(hpwf_pkg::atan_entry(step_ff))
                           : -18'(hpwf_pkg::atan_entry(step_ff))) - 18'(yaw_ff);
         end
      end
      if (cmd.wrap) begin
         err_ff <= werr;
         e16_ff <= 16'(werr);
      end
      if (cmd.decide && status.turn) begin
         left_ff <= err_ff > 0 ? -16'(half) : 16'(half);
         right_ff <= err_ff > 0 ? 16'(half) : -16'(half);
      end
      if (cmd.mul_p) acc_ff <= 50'(gain_p_ff) * 50'(e16_ff);
      if (cmd.mul_i) acc_ff <= acc_ff + 50'(gain_i_ff) * 50'(sum_new_ff);
      if (cmd.mul_d) acc_ff <= acc_ff + 50'(gain_d_ff) * 50'(deriv);
      if (cmd.round) begin
         left_ff <= clampv(left_raw, maxs);
         right_ff <= clampv(right_raw, maxs);
      end
      if (cmd.finish) begin
         rsp_left_ff <= left_ff;
         rsp_right_ff <= right_ff;
         rsp_reached_ff <= reached_ff;
      end
   end

   assign out_busy = valid_ff && rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_left_speed = rsp_left_ff;
   assign rsp_right_speed = rsp_right_ff;
   assign rsp_waypoint_reached = rsp_reached_ff;
endmodule
`default_nettype wire

// ===== design/heading_pid_waypoint_follower_unit.sv =====
// Top level of the heading PID waypoint follower.
// Usage: the requester presents a pose and waypoint word on req_* with
// req_valid high; it is taken when req_stall is low. One rsp_* word follows,
// carrying the two wheel speeds and the waypoint reached flag.
// An arrived waypoint skips the CORDIC stage; an in-place turn runs the 14
// steps of the shared CORDIC stage, and a PID update also runs the three
// sequential gain multiplies.
// One word is processed at a time, so a new request is taken only once the
// previous result has been moved to the output register.
// The result stays in an output register while rsp_stall is high; the next
// word is computed meanwhile and waits until that register is free.
// Configuration writes through csr_* take effect at once; the user makes
// them only while the block is idle, unchecked; unknown indexes are ignored.
// A synchronous reset loads the register defaults and clears the integral
// and the previous error, and drops any pending word.
`default_nettype none
module heading_pid_waypoint_follower_unit (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic signed [31:0] req_pose_x,
   input  wire logic signed [31:0] req_pose_y,
   input  wire logic signed [15:0] req_pose_yaw,
   input  wire logic signed [31:0] req_goal_x,
   input  wire logic signed [31:0] req_goal_y,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic signed [15:0] rsp_left_speed,
   output logic signed [15:0] rsp_right_speed,
   output logic rsp_waypoint_reached,
   input  wire logic csr_write,
   input  wire logic [2:0] csr_index,
   input  wire logic [15:0] csr_data
);
   hpwf_pkg::cmd_type cmd;
   hpwf_pkg::status_type status;
   logic out_busy;

   hpwf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .out_busy(out_busy), .status(status), .cmd(cmd)
   );

   hpwf_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status), .out_busy(out_busy),
      .req_pose_x(req_pose_x), .req_pose_y(req_pose_y), .req_pose_yaw(req_pose_yaw),
      .req_goal_x(req_goal_x), .req_goal_y(req_goal_y),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_left_speed(rsp_left_speed),
      .rsp_right_speed(rsp_right_speed), .rsp_waypoint_reached(rsp_waypoint_reached)
   );
endmodule
`default_nettype wire

// ===== design/hpwf_checker.sv =====
// Port-level checker for the waypoint follower, bound to the top level.
`default_nettype none
module hpwf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic signed [15:0] rsp_left_speed,
   input wire logic signed [15:0] rsp_right_speed,
   input wire logic rsp_waypoint_reached
);
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_speed))
      else $error("stalled response word changed");
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_waypoint_reached |-> rsp_left_speed == 0 && rsp_right_speed == 0)
      else $error("reached word with nonzero speed");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_right_speed) && $stable(rsp_waypoint_reached))
      else $error("stalled response flag or right speed changed");
endmodule

bind heading_pid_waypoint_follower_unit hpwf_checker u_hpwf_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_left_speed(rsp_left_speed),
   .rsp_right_speed(rsp_right_speed), .rsp_waypoint_reached(rsp_waypoint_reached)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the heading PID waypoint follower unit.
`timescale 1ns / 100ps
module tb;
   localparam longint ANGLE_PI = 25736;
   localparam longint ANGLE_TWO_PI = 51472;
   localparam int ITEMS_PER_PHASE = 66;
   localparam int PHASE_COUNT = 8;

   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic reached;
   } wheel_cmd_type;

   typedef struct {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [15:0] yaw;
      logic signed [31:0] gx;
      logic signed [31:0] gy;
      bit known;
      wheel_cmd_type cmd;
   } pose_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_pose_x = '0;
   logic signed [31:0] req_pose_y = '0;
   logic signed [15:0] req_pose_yaw = '0;
   logic signed [31:0] req_goal_x = '0;
   logic signed [31:0] req_goal_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_left_speed;
   logic signed [15:0] rsp_right_speed;
   logic rsp_waypoint_reached;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   heading_pid_waypoint_follower_unit u_dut (.*);

   always #5 clock = ~clock;

   longint turn_limit, top_speed, kp, ki, kd, reach_radius;
   longint integral, last_err;
   wheel_cmd_type pending_cmds[$];
   pose_row_type directed_rows[$];
   int mismatch_count = 0;
   int burst_left = 0;

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      mismatch_count++;
   endtask

   function automatic longint heading_to(input longint dx, input longint dy);
      longint x, y, z, xs, ys;
      x = dx;
      y = dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? ANGLE_PI : -ANGLE_PI;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < hpwf_pkg::CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys;
            y -= xs;
            z += longint'(hpwf_pkg::atan_entry(i[3:0]));
         end else begin
            x -= ys;
            y += xs;
            z -= longint'(hpwf_pkg::atan_entry(i[3:0]));
         end
      end
      return z;
   endfunction

   function automatic wheel_cmd_type steer_predict(input logic signed [31:0] px, py,
                                                   input logic signed [15:0] yaw,
                                                   input logic signed [31:0] gx, gy);
      wheel_cmd_type c;
      longint dx, dy, err, half, corr, acc, deriv, lft, rgt;
      dx = longint'(gx) - longint'(px);
      dy = longint'(gy) - longint'(py);
      c.reached = 1'b0;
      if ((dx < 0 ? -dx : dx) < reach_radius && (dy < 0 ? -dy : dy) < reach_radius &&
          dx * dx + dy * dy < reach_radius * reach_radius) begin
         c.left = '0;
         c.right = '0;
         c.reached = 1'b1;
         return c;
      end
      err = heading_to(dx, dy) - longint'(yaw);
      while (err > ANGLE_PI) err -= ANGLE_TWO_PI;
      while (err < -ANGLE_PI) err += ANGLE_TWO_PI;
      half = top_speed >> 1;
      if ((err < 0 ? -err : err) > turn_limit) begin
         lft = (err > 0) ? -half : half;
         rgt = -lft;
      end else begin
         integral += err;
         if (integral > 64'sd2147483647) integral = 64'sd2147483647;
         if (integral < -64'sd2147483648) integral = -64'sd2147483648;
         deriv = err - last_err;
         last_err = err;
         acc = kp * err + ki * integral + kd * deriv;
         corr = (acc + (64'sd1 << 20)) >>> 21;
         lft = half - corr;
         rgt = half + corr;
         if (lft > top_speed) lft = top_speed;
         if (lft < -top_speed) lft = -top_speed;
         if (rgt > top_speed) rgt = top_speed;
         if (rgt < -top_speed) rgt = -top_speed;
      end
      c.left = lft[15:0];
      c.right = rgt[15:0];
      return c;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input longint value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value[15:0];
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         hpwf_pkg::REG_TURN_THRESHOLD: turn_limit = value & 16'h7FFF;
         hpwf_pkg::REG_MAX_SPEED: top_speed = value & 16'h7FFF;
         hpwf_pkg::REG_GAIN_P: kp = longint'($signed(value[15:0]));
         hpwf_pkg::REG_GAIN_I: ki = longint'($signed(value[15:0]));
         hpwf_pkg::REG_GAIN_D: kd = longint'($signed(value[15:0]));
         hpwf_pkg::REG_ARRIVE_RADIUS: reach_radius = value & 16'hFFFF;
         default: ;
      endcase
   endtask

   task automatic drain_and_hold();
      req_valid = 1'b0;
      burst_left = 0;
      wait (pending_cmds.size() == 0);
      repeat (30) @(negedge clock);
   endtask

   task automatic send_word(input pose_row_type row);
      wheel_cmd_type c;
      if (burst_left == 0) begin
         req_valid = 1'b0;
         if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_valid = 1'b1;
      req_pose_x = row.px;
      req_pose_y = row.py;
      req_pose_yaw = row.yaw;
      req_goal_x = row.gx;
      req_goal_y = row.gy;
      do @(posedge clock); while (req_stall);
      c = steer_predict(row.px, row.py, row.yaw, row.gx, row.gy);
      pending_cmds = {pending_cmds, (row.known ? row.cmd : c)};
      burst_left--;
      @(negedge clock);
   endtask

   task automatic add_row(input logic signed [31:0] px, py, input logic signed [15:0] yaw,
                          input logic signed [31:0] gx, gy, input bit known,
                          input logic signed [15:0] l, r, input logic reached);
      pose_row_type row;
      row.px = px;
      row.py = py;
      row.yaw = yaw;
      row.gx = gx;
      row.gy = gy;
      row.known = known;
      row.cmd.left = l;
      row.cmd.right = r;
      row.cmd.reached = reached;
      directed_rows = {directed_rows, row};
   endtask

   function automatic pose_row_type random_row();
      pose_row_type row;
      longint off, b, e, rad;
      int kind;
      kind = $urandom_range(0, 9);
      rad = reach_radius + 2;
      row.known = 0;
      row.px = $urandom;
      row.py = $urandom;
      row.yaw = $urandom_range(0, 51472) - 25736;
      if (kind == 0) begin
         row.gx = $urandom;
         row.gy = $urandom;
         row.yaw = $urandom;
      end else if (kind == 1) begin
         row.gx = row.px;
         row.gy = row.py;
      end else if (kind <= 3) begin
         off = longint'($urandom_range(0, 2 * rad)) - rad;
         row.gx = row.px + off[31:0];
         off = longint'($urandom_range(0, 2 * rad)) - rad;
         row.gy = row.py + off[31:0];
      end else begin
         row.px = $signed($urandom) >>> $urandom_range(0, 12);
         row.py = $signed($urandom) >>> $urandom_range(0, 12);
         off = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
         row.gx = row.px + off[31:0];
         off = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
         row.gy = row.py + off[31:0];
         b = heading_to(longint'(row.gx) - longint'(row.px),
                        longint'(row.gy) - longint'(row.py));
         e = longint'($urandom_range(0, 2 * turn_limit + 600)) - turn_limit - 300;
         e = b - e;
         if (e > ANGLE_PI) e -= ANGLE_TWO_PI;
         if (e < -ANGLE_PI) e += ANGLE_TWO_PI;
         row.yaw = e[15:0];
      end
      return row;
   endfunction

   always @(negedge clock) begin : receiver_pattern
      static int mode = 0;
      static int left_in_mode = 20;
      if (left_in_mode == 0) begin
         mode = $urandom_range(0, 2);
         left_in_mode = $urandom_range(10, 60);
      end
      left_in_mode--;
      case (mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 1) == 1);
         default: rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   always @(posedge clock) begin : result_check
      wheel_cmd_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cmds.size() == 0) begin
            flag_mismatch("unexpected result words", 1, 0);
         end else begin
            want = pending_cmds.pop_front();
            if (rsp_left_speed !== want.left)
               flag_mismatch("left_speed", rsp_left_speed, want.left);
            if (rsp_right_speed !== want.right)
               flag_mismatch("right_speed", rsp_right_speed, want.right);
            if (rsp_waypoint_reached !== want.reached)
               flag_mismatch("waypoint_reached", rsp_waypoint_reached, want.reached);
         end
      end
   end

   initial begin
      #20ms;
      $display("tb failed");
      $finish;
   end

   initial begin
      longint setting[6];
      turn_limit = 8192;
      top_speed = 16384;
      kp = 256;
      ki = 0;
      kd = 0;
      reach_radius = 655;
      integral = 0;
      last_err = 0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      add_row(0, 0, 0, 0, 0, 1, 0, 0, 1);
      add_row(100, -7, 3, 754, -7, 1, 0, 0, 1);
      add_row(-2147483648, 2147483647, 0, -2147483648, 2147483647, 1, 0, 0, 1);
      add_row(0, 0, -25736, 0, 65536, 1, 8192, -8192, 0);
      add_row(0, 0, 25736, 0, -65536, 1, -8192, 8192, 0);
      add_row(0, 0, 0, 655, 0, 0, 0, 0, 0);
      add_row(0, 0, 0, 65536, 0, 0, 0, 0, 0);
      add_row(0, 0, 100, 65536, 1000, 0, 0, 0, 0);
      add_row(0, 0, 0, -65536, 0, 0, 0, 0, 0);
      add_row(0, 0, 0, -65536, -1, 0, 0, 0, 0);
      add_row(-2147483648, 0, 0, 2147483647, 0, 0, 0, 0, 0);
      add_row(2147483647, 0, 0, -2147483648, 0, 0, 0, 0, 0);
      add_row(0, -2147483648, 0, 0, 2147483647, 0, 0, 0, 0);
      add_row(0, 2147483647, 0, 0, -2147483648, 0, 0, 0, 0);
      add_row(0, 0, 25736, 65536, 65536, 0, 0, 0, 0);
      add_row(0, 0, -25736, 65536, -65536, 0, 0, 0, 0);
      add_row(0, 0, -32768, 65536, 0, 0, 0, 0, 0);
      add_row(0, 0, 32767, -65536, 5, 0, 0, 0, 0);
      add_row(-1, -1, 0, 0, 0, 1, 0, 0, 1);
      add_row(0, 0, 8000, 65536, 0, 0, 0, 0, 0);
      foreach (directed_rows[i]) send_word(directed_rows[i]);
      drain_and_hold();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0: setting = '{8192, 16384, 256, 0, 0, 655};
            1: setting = '{0, 32767, 32767, 32767, 32767, 0};
            2: setting = '{25736, 0, -32768, -32768, -32768, 65535};
            3: setting = '{25736, 32767, -32768, 32767, -32768, 65535};
            default: setting = '{$urandom_range(0, 25736), $urandom_range(0, 32767),
                                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(0, 65535)};
         endcase
         write_reg(hpwf_pkg::REG_TURN_THRESHOLD, setting[0]);
         write_reg(hpwf_pkg::REG_MAX_SPEED, setting[1]);
         write_reg(hpwf_pkg::REG_GAIN_P, setting[2]);
         write_reg(hpwf_pkg::REG_GAIN_I, setting[3]);
         write_reg(hpwf_pkg::REG_GAIN_D, setting[4]);
         write_reg(hpwf_pkg::REG_ARRIVE_RADIUS, setting[5]);
         if (ph == 1) begin
            write_reg(3'd6, 16'hFFFF);
            write_reg(3'd7, 16'h1234);
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == 4 && n == 30) begin
               req_valid = 1'b0;
               burst_left = 0;
               wait (pending_cmds.size() == 0);
               @(negedge clock);
            end
            send_word(random_row());
         end
         drain_and_hold();
      end

      req_valid = 1'b0;
      wait (pending_cmds.size() == 0);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end
endmodule
